@@ sv/bblcd_pkg.sv @@
// ----------------------------------------------------------------------------
// bblcd_pkg
// Shared widths, codes and controller/datapath bundles for the byte budget
// lru cache directory.
// ----------------------------------------------------------------------------
package bblcd_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int TAG_BITS_DEF = 64;

  localparam int KEY_W   = 64;
  localparam int SIZE_W  = 20;
  localparam int CAP_W   = 24;
  localparam int TOTAL_W = 25;
  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 24'd1048576;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_HIT    = 2'd0,
    KIND_MISS   = 2'd1,
    KIND_EVICT  = 2'd2,
    KIND_INSERT = 2'd3
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch the accepted transaction
    logic idx_clr;
    logic idx_inc;
    logic lk_cmp;    // tag compare of the entry addressed this cycle
    logic rd_best;   // read the best hit entry
    logic slot_ld;   // capture scan index as victim or free slot
    logic lk_done;   // emit lookup result, reorder on hit
    logic ev_take;   // emit eviction, drop entry
    logic ins_take;  // emit insert, fill entry
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_last;
    logic ev_need;
    logic ev_match;
    logic free_match;
  } sts_t;

endpackage

@@ sv/bblcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// bblcd_ctrl
// Sequencer for lookup scans, eviction loop and insert of the directory.
// ----------------------------------------------------------------------------
module bblcd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_operation,
  input  bblcd_pkg::sts_t   sts,
  output bblcd_pkg::cmd_t   cmd,
  output logic              busy
);
  import bblcd_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_LK_SCAN  = 10'b00_0000_0010,
    S_LK_WAIT  = 10'b00_0000_0100,
    S_LK_READ  = 10'b00_0000_1000,
    S_LK_OUT   = 10'b00_0001_0000,
    S_EV_CHECK = 10'b00_0010_0000,
    S_EV_SCAN  = 10'b00_0100_0000,
    S_EV_OUT   = 10'b00_1000_0000,
    S_INS_SCAN = 10'b01_0000_0000,
    S_INS_OUT  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = (in_operation == OP_INSERT) ? S_EV_CHECK : S_LK_SCAN;
        end
      end
      S_LK_SCAN: begin
        cmd.lk_cmp  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_LK_WAIT;
        end
      end
      S_LK_WAIT: begin
        state_nxt = S_LK_READ;
      end
      S_LK_READ: begin
        cmd.rd_best = 1'b1;
        state_nxt   = S_LK_OUT;
      end
      S_LK_OUT: begin
        cmd.lk_done = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_EV_CHECK: begin
        cmd.idx_clr = 1'b1;
        state_nxt   = sts.ev_need ? S_EV_SCAN : S_INS_SCAN;
      end
      S_EV_SCAN: begin
        if (sts.ev_match) begin
          cmd.slot_ld = 1'b1;
          state_nxt   = S_EV_OUT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_EV_OUT: begin
        cmd.ev_take = 1'b1;
        state_nxt   = S_EV_CHECK;
      end
      S_INS_SCAN: begin
        if (sts.free_match) begin
          cmd.slot_ld = 1'b1;
          state_nxt   = S_INS_OUT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_INS_OUT: begin
        cmd.ins_take = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ sv/bblcd_dpath.sv @@
// ----------------------------------------------------------------------------
// bblcd_dpath
// Entry store, recency ranks, byte total and result register of the
// directory.
// ----------------------------------------------------------------------------
module bblcd_dpath #(
  parameter int ENTRIES  = bblcd_pkg::ENTRIES_DEF,
  parameter int TAG_BITS = bblcd_pkg::TAG_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [bblcd_pkg::CAP_W-1:0]     cfg_wr_data,
  input  logic [bblcd_pkg::KEY_W-1:0]     in_key,
  input  logic [bblcd_pkg::SIZE_W-1:0]    in_object_size,
  input  bblcd_pkg::cmd_t                 cmd,
  output bblcd_pkg::sts_t                 sts,
  output logic                            out_valid,
  output logic [bblcd_pkg::KIND_W-1:0]    out_kind,
  output logic [bblcd_pkg::SLOT_W-1:0]    out_slot,
  output logic [bblcd_pkg::KEY_W-1:0]     out_entry_key,
  output logic [bblcd_pkg::SIZE_W-1:0]    out_entry_size,
  output logic                            out_last
);
  import bblcd_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int MEM_W = TAG_BITS + SIZE_W;
  localparam int SUM_W = TOTAL_W + 1;
  localparam logic [IDX_W-1:0] IDX_MAX  = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);

  logic [CAP_W-1:0]    cap_r;
  logic [TAG_BITS-1:0] key_r;
  logic [SIZE_W-1:0]   size_r;
  logic [IDX_W-1:0]    idx_r;
  logic                cmp_en_r;
  logic [IDX_W-1:0]    cmp_idx_r;
  logic                hit_r;
  logic [IDX_W-1:0]    best_r;
  logic [IDX_W-1:0]    best_rank_r;
  logic [IDX_W-1:0]    slot_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [TOTAL_W-1:0]  total_r;
  logic [ENTRIES-1:0]  valid_r;
  logic [IDX_W-1:0]    rank_r [ENTRIES];
  logic [MEM_W-1:0]    mem [ENTRIES];
  logic [MEM_W-1:0]    rd_data_r;

  logic                out_valid_r;
  kind_t               out_kind_r;
  logic [IDX_W-1:0]    out_slot_r;
  logic [TAG_BITS-1:0] out_tag_r;
  logic [SIZE_W-1:0]   out_size_r;
  logic                out_last_r;

  logic [IDX_W-1:0]    rd_addr;
  logic [TAG_BITS-1:0] rd_tag;
  logic [SIZE_W-1:0]   rd_size;
  logic                cand;
  logic [IDX_W-1:0]    cnt_m1;
  logic [SUM_W-1:0]    need_sum;
  logic                over;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= in_key[TAG_BITS-1:0];
      size_r <= in_object_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= (idx_r == IDX_MAX) ? '0 : idx_r + 1'b1;
    end
  end

  // entry store: tag in the low bits, size above
  assign rd_addr = cmd.rd_best ? best_r : idx_r;

  always_ff @(posedge clk) begin
    if (cmd.ins_take) begin
      mem[slot_r] <= {size_r, key_r};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_tag  = rd_data_r[TAG_BITS-1:0];
  assign rd_size = rd_data_r[MEM_W-1:TAG_BITS];

  // compare stage works on the index of the cycle before, in step with the read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_en_r <= 1'b0;
    end else begin
      cmp_en_r <= cmd.lk_cmp;
    end
    cmp_idx_r <= idx_r;
  end

  assign cand = cmp_en_r && valid_r[cmp_idx_r] && (rd_tag == key_r) &&
                (!hit_r || (rank_r[cmp_idx_r] < best_rank_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.load) begin
      hit_r <= 1'b0;
    end else if (cand) begin
      hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cand) begin
      best_r      <= cmp_idx_r;
      best_rank_r <= rank_r[cmp_idx_r];
    end
    if (cmd.slot_ld) begin
      slot_r <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
      total_r <= '0;
    end else if (cmd.ev_take) begin
      valid_r[slot_r] <= 1'b0;
      cnt_r           <= cnt_r - 1'b1;
      total_r         <= total_r - TOTAL_W'(rd_size);
    end else if (cmd.ins_take) begin
      valid_r[slot_r] <= 1'b1;
      cnt_r           <= cnt_r + 1'b1;
      total_r         <= total_r + TOTAL_W'(size_r);
    end
  end

  // each rank cell ages or resets on its own
  always_ff @(posedge clk) begin
    for (int j = 0; j < ENTRIES; j++) begin
      if (cmd.ins_take) begin
        if (slot_r == IDX_W'(j)) begin
          rank_r[j] <= '0;
        end else if (valid_r[j]) begin
          rank_r[j] <= rank_r[j] + 1'b1;
        end
      end else if (cmd.lk_done && hit_r) begin
        if (best_r == IDX_W'(j)) begin
          rank_r[j] <= '0;
        end else if (valid_r[j] && (rank_r[j] < best_rank_r)) begin
          rank_r[j] <= rank_r[j] + 1'b1;
        end
      end
    end
  end

  assign cnt_m1   = IDX_W'(cnt_r - 1'b1);
  assign need_sum = SUM_W'(total_r) + SUM_W'(size_r);
  assign over     = need_sum > SUM_W'(cap_r);

  assign sts.idx_last   = (idx_r == IDX_MAX);
  assign sts.ev_need    = (cnt_r != '0) && (over || (cnt_r == CNT_FULL));
  assign sts.ev_match   = valid_r[idx_r] && (rank_r[idx_r] == cnt_m1);
  assign sts.free_match = !valid_r[idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.lk_done || cmd.ev_take || cmd.ins_take;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lk_done) begin
      out_kind_r <= hit_r ? KIND_HIT : KIND_MISS;
      out_slot_r <= hit_r ? best_r : '0;
      out_tag_r  <= hit_r ? rd_tag : '0;
      out_size_r <= hit_r ? rd_size : '0;
      out_last_r <= 1'b1;
    end else if (cmd.ev_take) begin
      out_kind_r <= KIND_EVICT;
      out_slot_r <= slot_r;
      out_tag_r  <= rd_tag;
      out_size_r <= rd_size;
      out_last_r <= 1'b0;
    end else if (cmd.ins_take) begin
      out_kind_r <= KIND_INSERT;
      out_slot_r <= slot_r;
      out_tag_r  <= key_r;
      out_size_r <= size_r;
      out_last_r <= 1'b1;
    end
  end

  // zero-extend or truncate through a wider view
  logic [IDX_W+SLOT_W-1:0]    slot_wide;
  logic [TAG_BITS+KEY_W-1:0]  key_wide;

  assign slot_wide = {{SLOT_W{1'b0}}, out_slot_r};
  assign key_wide  = {{KEY_W{1'b0}}, out_tag_r};

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_slot       = slot_wide[SLOT_W-1:0];
  assign out_entry_key  = key_wide[KEY_W-1:0];
  assign out_entry_size = out_size_r;
  assign out_last       = out_last_r;

  a_cnt_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'($countones(valid_r)))
    else $error("entry count out of step with valid bits");

  a_insert_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_take |=> valid_r[$past(slot_r)])
    else $error("inserted slot not marked valid");

  a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ev_take |-> (cnt_r != '0) && valid_r[slot_r])
    else $error("eviction of an empty slot");

  a_last_isolated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |=> !out_valid_r)
    else $error("result follows final result of a transaction");

  a_insert_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_take |-> (cnt_r != CNT_FULL) && (!over || (cnt_r == '0)))
    else $error("insert without room");

endmodule

@@ sv/byte_budget_lru_cache_directory.sv @@
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_directory
// LRU directory of a variable-size object cache held under a byte budget.
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken while busy is low. A lookup
// walks all ENTRIES slots through the single-port entry store and returns
// one result. An insert that evicts k entries runs one victim scan for
// each eviction, then scans for the lowest free slot and fills it; each
// eviction and the insert give one result. Results appear on out_* for
// one cycle with out_valid and cannot be held off; out_last marks the
// final one. The user must write capacity_bytes through cfg_wr_en only
// while busy is low and no result is outstanding; the block itself does
// not enforce this.
module byte_budget_lru_cache_directory #(
  parameter int ENTRIES  = bblcd_pkg::ENTRIES_DEF,
  parameter int TAG_BITS = bblcd_pkg::TAG_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [bblcd_pkg::CAP_W-1:0]     cfg_wr_data,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_operation,
  input  logic [bblcd_pkg::KEY_W-1:0]     in_key,
  input  logic [bblcd_pkg::SIZE_W-1:0]    in_object_size,
  output logic                            out_valid,
  output logic [bblcd_pkg::KIND_W-1:0]    out_kind,
  output logic [bblcd_pkg::SLOT_W-1:0]    out_slot,
  output logic [bblcd_pkg::KEY_W-1:0]     out_entry_key,
  output logic [bblcd_pkg::SIZE_W-1:0]    out_entry_size,
  output logic                            out_last
);
  import bblcd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bblcd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy)
  );

  bblcd_dpath #(
    .ENTRIES  (ENTRIES),
    .TAG_BITS (TAG_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_key         (in_key),
    .in_object_size (in_object_size),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_slot       (out_slot),
    .out_entry_key  (out_entry_key),
    .out_entry_size (out_entry_size),
    .out_last       (out_last)
  );

endmodule
